// File: hdl/pktab_pkg.sv
// Shared types and constants for the packed key table.
// No dependencies; used by the RAM-backed table top level.
package pktab_pkg;

  localparam int unsigned KEY_W   = 32;
  localparam int unsigned PAY_W   = 64;
  localparam int unsigned TOTAL_W = 7;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_LOOKUP = 2'd1,
    OP_DELETE = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_DUP     = 2'd2,
    ST_MISSING = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT
  } state_e;

  typedef struct packed {
    op_e                      operation;
    logic signed [KEY_W-1:0]  key;
    logic [PAY_W-1:0]         payload;
  } req_t;

  typedef struct packed {
    status_e                  status;
    logic [PAY_W-1:0]         found_payload;
    logic [TOTAL_W-1:0]       entry_total;
  } rsp_t;

  typedef struct packed {
    logic signed [KEY_W-1:0]  key;
    logic [PAY_W-1:0]         payload;
  } entry_t;

endpackage

// File: hdl/pktab_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No package dependencies.
module pktab_ram #(
  parameter int unsigned WIDTH = 96,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// File: hdl/packed_key_table_insert_lookup_delete.sv
// Packed key table top level: FSM, scan/shift datapath and result register.
// Depends on pktab_pkg (types, codes) and pktab_ram (entry storage).
//
// Usage:
//   A request (operation, key, payload on req_i) is taken at a rising edge
//   where start is high and busy is low. busy stays high while the request
//   is worked on. Exactly one response per request appears on rsp_o for a
//   single cycle, flagged by done_o; the receiver cannot stall it, and a new
//   request may be started in the very cycle done_o is high.
//   Entries live in one RAM ({key, payload} per word, registered read)
//   and are kept packed at addresses 0 .. count-1.
// Steps from the accept to the response (p = match position):
//   full insert / unused op : done_o rises right after the accept
//   lookup / insert         : entries 0 .. p are read on a hit, all
//                             entries on a miss (none when empty);
//                             one read issued per cycle through the RAM
//   delete                  : scan as above, then the entries above p are
//                             shifted (read k+1, write k, pipelined), with
//                             no shifting when the last entry goes
//   Scan and shift together pass each held entry once, so the worst case is
//   a delete in a full table.
// Reset: count and control clear at once; RAM contents are not cleared
// since only entries below the count are ever read. No clearing pass.
module packed_key_table_insert_lookup_delete #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  input  pktab_pkg::req_t    req_i,
  output logic               busy,
  output logic               done_o,
  output pktab_pkg::rsp_t    rsp_o
);

  localparam int unsigned IDX_W = $clog2(CAPACITY);
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned ENT_W = $bits(pktab_pkg::entry_t);

  // FSM and request latches
  pktab_pkg::state_e  state_q, state_d;
  pktab_pkg::req_t    req_q, req_d;
  logic [CNT_W-1:0]   count_q, count_d;

  // Scan / shift pipeline: rd_idx is the next read address, cmp_idx the
  // address whose data is on the RAM output when rv is set.
  logic [CNT_W-1:0]   rd_idx_q, rd_idx_d;
  logic [IDX_W-1:0]   cmp_idx_q, cmp_idx_d;
  logic               rv_q, rv_d;

  // Result register
  logic               done_q, done_d;
  pktab_pkg::rsp_t    rsp_q, rsp_d;

  // RAM port signals
  logic               ram_we, ram_re;
  logic [IDX_W-1:0]   ram_waddr;
  pktab_pkg::entry_t  ram_wdata, ram_rdata;

  logic               accept;
  logic               rd_more;
  logic               hit;
  logic               scan_end;
  logic [CNT_W+pktab_pkg::TOTAL_W-1:0] total_ext;

  assign accept   = start && !busy;
  assign rd_more  = rd_idx_q < count_q;
  assign hit      = rv_q && (ram_rdata.key == req_q.key);
  // nothing in flight and nothing left to read
  assign scan_end = !rv_q && !rd_more;
  assign total_ext = {{pktab_pkg::TOTAL_W{1'b0}}, count_d};

  // ---------------------------------------------------------------
  // Next state
  // ---------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      pktab_pkg::S_IDLE: begin
        if (accept) begin
          case (req_i.operation)
            pktab_pkg::OP_INSERT: begin
              if (count_q != CNT_W'(CAPACITY)) begin
                state_d = pktab_pkg::S_SCAN;
              end
            end
            pktab_pkg::OP_LOOKUP, pktab_pkg::OP_DELETE: begin
              state_d = pktab_pkg::S_SCAN;
            end
            default: state_d = pktab_pkg::S_IDLE;
          endcase
        end
      end
      pktab_pkg::S_SCAN: begin
        if (hit) begin
          state_d = (req_q.operation == pktab_pkg::OP_DELETE) ?
                    pktab_pkg::S_SHIFT : pktab_pkg::S_IDLE;
        end else if (scan_end) begin
          state_d = pktab_pkg::S_IDLE;
        end
      end
      pktab_pkg::S_SHIFT: begin
        if (scan_end) begin
          state_d = pktab_pkg::S_IDLE;
        end
      end
      default: state_d = pktab_pkg::S_IDLE;
    endcase
  end

  // ---------------------------------------------------------------
  // Datapath, RAM control and result
  // ---------------------------------------------------------------
  always_comb begin
    req_d     = req_q;
    count_d   = count_q;
    rd_idx_d  = rd_idx_q;
    cmp_idx_d = cmp_idx_q;
    rv_d      = 1'b0;
    done_d    = 1'b0;
    rsp_d     = rsp_q;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_waddr = cmp_idx_q - IDX_W'(1);
    ram_wdata = ram_rdata;

    case (state_q)
      pktab_pkg::S_IDLE: begin
        if (accept) begin
          req_d    = req_i;
          rd_idx_d = '0;
          if (state_d == pktab_pkg::S_IDLE) begin
            // full insert or unused operation: answer at once
            done_d = 1'b1;
            rsp_d.status = (req_i.operation == pktab_pkg::OP_INSERT) ?
                           pktab_pkg::ST_FULL : pktab_pkg::ST_MISSING;
            rsp_d.found_payload = '0;
          end
        end
      end
      pktab_pkg::S_SCAN: begin
        if (hit) begin
          case (req_q.operation)
            pktab_pkg::OP_LOOKUP: begin
              done_d = 1'b1;
              rsp_d.status = pktab_pkg::ST_OK;
              rsp_d.found_payload = ram_rdata.payload;
            end
            pktab_pkg::OP_DELETE: begin
              // restart the read pipeline just past the hit
              rd_idx_d = CNT_W'(cmp_idx_q) + CNT_W'(1);
            end
            default: begin
              done_d = 1'b1;
              rsp_d.status = pktab_pkg::ST_DUP;
              rsp_d.found_payload = '0;
            end
          endcase
        end else if (scan_end) begin
          done_d = 1'b1;
          rsp_d.found_payload = '0;
          if (req_q.operation == pktab_pkg::OP_INSERT) begin
            ram_we    = 1'b1;
            ram_waddr = count_q[IDX_W-1:0];
            ram_wdata = '{key: req_q.key, payload: req_q.payload};
            count_d   = count_q + CNT_W'(1);
            rsp_d.status = pktab_pkg::ST_OK;
          end else begin
            rsp_d.status = pktab_pkg::ST_MISSING;
          end
        end else begin
          ram_re    = rd_more;
          rv_d      = rd_more;
          cmp_idx_d = rd_idx_q[IDX_W-1:0];
          rd_idx_d  = rd_idx_q + CNT_W'(rd_more);
        end
      end
      pktab_pkg::S_SHIFT: begin
        // move the entry read last cycle down one place
        ram_we = rv_q;
        if (scan_end) begin
          done_d  = 1'b1;
          count_d = count_q - CNT_W'(1);
          rsp_d.status = pktab_pkg::ST_OK;
          rsp_d.found_payload = '0;
        end else begin
          ram_re    = rd_more;
          rv_d      = rd_more;
          cmp_idx_d = rd_idx_q[IDX_W-1:0];
          rd_idx_d  = rd_idx_q + CNT_W'(rd_more);
        end
      end
      default: ;
    endcase

    rsp_d.entry_total = total_ext[pktab_pkg::TOTAL_W-1:0];
  end

  // ---------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pktab_pkg::S_IDLE;
      count_q <= '0;
      rv_q    <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      rv_q    <= rv_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q     <= req_d;
    rd_idx_q  <= rd_idx_d;
    cmp_idx_q <= cmp_idx_d;
    rsp_q     <= rsp_d;
  end

  pktab_ram #(
    .WIDTH (ENT_W),
    .DEPTH (CAPACITY)
  ) u_entries (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (rd_idx_q[IDX_W-1:0]),
    .rdata_o (ram_rdata)
  );

  assign busy   = (state_q != pktab_pkg::S_IDLE);
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  // ---------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------
  a_count_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_done_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("response while still busy");

  a_accept_progress : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (busy || done_o))
    else $error("accepted request neither worked on nor answered");

  a_shift_addr : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_we && state_q == pktab_pkg::S_SHIFT) |->
      (CNT_W'(ram_waddr) < count_q))
    else $error("shift write outside held entries");

  a_shift_order : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_we && ram_re) |-> (CNT_W'(ram_waddr) < rd_idx_q))
    else $error("shift write not below read address");

endmodule
